// ===== hdl/btas_pkg.sv =====
// ----------------------------------------------------------------------------
// btas_pkg - block transfer address sequencer package
// Shared widths, constants and the control struct passed from the sequencer.
// ----------------------------------------------------------------------------
package btas_pkg;

  localparam int NUM_REGS  = 16;
  localparam int REG_W     = 4;
  localparam int ADDR_W    = 32;

  localparam logic [REG_W-1:0]  PC_REG    = 4'd15;
  localparam logic [ADDR_W-1:0] WORD_STEP = 32'd4;

  typedef struct packed {
    logic             busy;     // an instruction is being expanded
    logic             advance;  // a result is produced this cycle
    logic             empty;    // register list was empty
    logic             last;     // this transfer is the final one
    logic [REG_W-1:0] reg_idx;  // register of this transfer
  } seq_ctrl_t;

endpackage

// ===== hdl/btas_addr_unit.sv =====
// ----------------------------------------------------------------------------
// btas_addr_unit - shared address adder
// Holds the running address base +/- 4k and steps it by one word per transfer.
// ----------------------------------------------------------------------------
module btas_addr_unit (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        advance,
  input  logic                        up,
  input  logic [btas_pkg::ADDR_W-1:0] base,
  output logic [btas_pkg::ADDR_W-1:0] acc,
  output logic [btas_pkg::ADDR_W-1:0] sum
);

  logic [btas_pkg::ADDR_W-1:0] acc_next;

  // single adder: acc + 4 or acc - 4
  assign sum = up ? (acc + btas_pkg::WORD_STEP) : (acc - btas_pkg::WORD_STEP);

  always_comb begin
    acc_next = acc;
    if (load) begin
      acc_next = base;
    end else if (advance) begin
      acc_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

// ===== hdl/btas_seq.sv =====
// ----------------------------------------------------------------------------
// btas_seq - register list sequencer
// Walks the register list one set bit per cycle, while the output is free, in transfer order.
// ----------------------------------------------------------------------------
module btas_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          up,
  input  logic [btas_pkg::NUM_REGS-1:0] reg_list,
  input  logic                          out_free,
  output btas_pkg::seq_ctrl_t           ctrl
);

  logic [btas_pkg::NUM_REGS-1:0] scan;
  logic [btas_pkg::NUM_REGS-1:0] scan_next;
  logic [btas_pkg::NUM_REGS-1:0] scan_rest;
  logic [btas_pkg::NUM_REGS-1:0] list_rev;
  logic                          busy;
  logic                          busy_next;
  logic                          dir_up;
  logic [btas_pkg::REG_W-1:0]    pos;

  // scan order: the lowest set bit of the scan mask is always the next register to visit
  always_comb begin
    for (int i = 0; i < btas_pkg::NUM_REGS; i++) begin
      list_rev[i] = reg_list[btas_pkg::NUM_REGS-1-i];
    end
  end

  // lowest set bit of the scan mask
  always_comb begin
    pos = '0;
    for (int i = btas_pkg::NUM_REGS-1; i >= 0; i--) begin
      if (scan[i]) begin
        pos = btas_pkg::REG_W'(i);
      end
    end
  end

  assign scan_rest = scan & (scan - btas_pkg::NUM_REGS'(1));

  always_comb begin
    ctrl.busy    = busy;
    ctrl.advance = busy && out_free;
    ctrl.empty   = (scan == '0);
    ctrl.last    = (scan_rest == '0);
    ctrl.reg_idx = dir_up ? pos : (btas_pkg::PC_REG - pos);
  end

  always_comb begin
    scan_next = scan;
    busy_next = busy;
    if (load) begin
      scan_next = up ? reg_list : list_rev;
      busy_next = 1'b1;
    end else if (ctrl.advance) begin
      scan_next = scan_rest;
      busy_next = !(ctrl.last || ctrl.empty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    if (load) begin
      dir_up <= up;
    end
  end

endmodule

// ===== hdl/block_transfer_address_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// block_transfer_address_sequencer_unit - block transfer address sequencer
// Expands one block transfer instruction into one word per listed register.
// ----------------------------------------------------------------------------
// Order: an accepted word loads the sequencer and address registers; each
//   result word is then registered in the output register. A new input word
//   is taken only after the last result of the previous one (an empty list
//   still yields one result word); one result per cycle while the output is free.
// Reset: synchronous, active high; clears busy and the output valid only.
// ----------------------------------------------------------------------------
module block_transfer_address_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [btas_pkg::NUM_REGS-1:0] reg_list,
  input  logic                          pre_index,
  input  logic                          up,
  input  logic                          write_back,
  input  logic                          is_load,
  input  logic [btas_pkg::REG_W-1:0]    base_reg,
  input  logic [btas_pkg::ADDR_W-1:0]   base_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          transfer_valid,
  output logic [btas_pkg::REG_W-1:0]    reg_index,
  output logic [btas_pkg::ADDR_W-1:0]   address,
  output logic                          load_op,
  output logic                          pc_plus_twelve,
  output logic                          base_update_valid,
  output logic [btas_pkg::REG_W-1:0]    update_reg,
  output logic [btas_pkg::ADDR_W-1:0]   new_base,
  output logic                          last
);

  btas_pkg::seq_ctrl_t         ctrl;
  logic                        load;
  logic                        out_free;
  logic [btas_pkg::ADDR_W-1:0] acc;
  logic [btas_pkg::ADDR_W-1:0] sum;

  // held instruction fields
  logic                        pre;
  logic                        dir_up;
  logic                        wb;
  logic                        ld;
  logic [btas_pkg::REG_W-1:0]  breg;

  logic                        fin;
  logic                        upv;

  // one instruction at a time; a new word is taken once the last result
  // has been handed to the output register. Nothing is taken during reset.
  assign in_ready = !ctrl.busy && !rst;
  assign load     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      pre    <= pre_index;
      dir_up <= up;
      wb     <= write_back;
      ld     <= is_load;
      breg   <= base_reg;
    end
  end

  btas_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .up       (up),
    .reg_list (reg_list),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // acc tracks base +/- 4k; sum is the next word address. Pre-indexed
  // transfers use sum, post-indexed use acc. After the final transfer sum
  // equals base +/- 4*count, the written-back base.
  btas_addr_unit u_addr (
    .clk     (clk),
    .load    (load),
    .advance (ctrl.advance),
    .up      (dir_up),
    .base    (base_value),
    .acc     (acc),
    .sum     (sum)
  );

  assign fin = ctrl.last || ctrl.empty;
  assign upv = fin && wb;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      transfer_valid    <= !ctrl.empty;
      reg_index         <= ctrl.empty ? '0 : ctrl.reg_idx;
      address           <= ctrl.empty ? '0 : (pre ? sum : acc);
      load_op           <= ld;
      // stores of the PC are flagged to carry PC plus 12
      pc_plus_twelve    <= !ctrl.empty && !ld && (ctrl.reg_idx == btas_pkg::PC_REG);
      base_update_valid <= upv;
      update_reg        <= upv ? breg : '0;
      // empty list: acc still holds the base itself
      new_base          <= upv ? (ctrl.empty ? acc : sum) : '0;
      last              <= fin;
    end
  end

  // checks
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer not busy after accepting an instruction");

  a_pc12_store_only : assert property (@(posedge clk) disable iff (rst)
    (out_valid && pc_plus_twelve) |->
      (transfer_valid && !load_op && reg_index == btas_pkg::PC_REG))
    else $error("PC plus 12 flagged on a word that is not a store of the PC");

  a_update_on_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (base_update_valid || !transfer_valid)) |-> last)
    else $error("writeback or empty-list word not marked last");

  a_idle_no_pending : assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && out_ready && in_ready) |=> (!out_valid || !in_ready))
    else $error("result produced while the sequencer was idle");

endmodule
